>>> src/y86_pkg.sv
// Shared types, constants and ALU/condition helpers for the Y86-64 step block.
// No dependencies.
package y86_pkg;

  localparam int MEM_BYTES = 8192;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int NUM_REGS  = 15;

  localparam logic [3:0] RSP_ID = 4'd4;
  localparam logic [3:0] NO_REG = 4'd15;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_EXEC  = 2'd1;
  localparam logic [1:0] ACT_RDQ   = 2'd2;
  localparam logic [1:0] ACT_RDREG = 2'd3;

  localparam logic [1:0] ST_AOK = 2'd0;
  localparam logic [1:0] ST_HLT = 2'd1;
  localparam logic [1:0] ST_ADR = 2'd2;
  localparam logic [1:0] ST_INS = 2'd3;

  localparam logic [3:0] OP_HALT  = 4'h0;
  localparam logic [3:0] OP_NOP   = 4'h1;
  localparam logic [3:0] OP_RRMOV = 4'h2;
  localparam logic [3:0] OP_IRMOV = 4'h3;
  localparam logic [3:0] OP_RMMOV = 4'h4;
  localparam logic [3:0] OP_MRMOV = 4'h5;
  localparam logic [3:0] OP_OPQ   = 4'h6;
  localparam logic [3:0] OP_JXX   = 4'h7;
  localparam logic [3:0] OP_CALL  = 4'h8;
  localparam logic [3:0] OP_RET   = 4'h9;
  localparam logic [3:0] OP_PUSH  = 4'hA;
  localparam logic [3:0] OP_POP   = 4'hB;
  localparam logic [3:0] OP_IADD  = 4'hC;

  localparam logic [3:0] ALU_ADD = 4'd0;
  localparam logic [3:0] ALU_SUB = 4'd1;
  localparam logic [3:0] ALU_AND = 4'd2;
  localparam logic [3:0] ALU_XOR = 4'd3;

  localparam logic [3:0] C_ALW = 4'd0;
  localparam logic [3:0] C_LE  = 4'd1;
  localparam logic [3:0] C_L   = 4'd2;
  localparam logic [3:0] C_E   = 4'd3;
  localparam logic [3:0] C_NE  = 4'd4;
  localparam logic [3:0] C_GE  = 4'd5;
  localparam logic [3:0] C_G   = 4'd6;

  localparam logic [2:0] FLAGS_RESET = 3'b100;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic        we;
    logic [3:0]  idx;
    logic [63:0] data;
  } rf_wr_t;

  function automatic logic byte_ok(logic [63:0] a);
    return a < 64'(MEM_BYTES);
  endfunction

  function automatic logic word_ok(logic [63:0] a);
    return a <= 64'(MEM_BYTES - 8);
  endfunction

  function automatic logic [63:0] alu_res(logic [3:0] fn, logic [63:0] a, logic [63:0] b);
    case (fn)
      ALU_ADD: return a + b;
      ALU_SUB: return b - a;
      ALU_AND: return a & b;
      ALU_XOR: return a ^ b;
      default: return '0;
    endcase
  endfunction

  // Z bit 2, S bit 1, O bit 0; subtract overflow keeps the odd "a > 0" test
  function automatic logic [2:0] alu_flg(logic [3:0] fn, logic [63:0] a, logic [63:0] b);
    logic [63:0] v;
    logic        o;
    logic        apos;
    v    = alu_res(fn, a, b);
    apos = (a != '0) && !a[63];
    case (fn)
      ALU_ADD: o = (a[63] == b[63]) && (v[63] != a[63]);
      ALU_SUB: o = (apos == b[63]) && (v[63] != b[63]);
      default: o = 1'b0;
    endcase
    return {(v == '0), v[63], o};
  endfunction

  function automatic logic cond_ok(logic [2:0] cc, logic [3:0] c);
    logic zf;
    logic sf;
    logic of;
    zf = cc[2];
    sf = cc[1];
    of = cc[0];
    case (c)
      C_ALW:   return 1'b1;
      C_LE:    return (sf ^ of) | zf;
      C_L:     return sf ^ of;
      C_E:     return zf;
      C_NE:    return !zf;
      C_GE:    return !(sf ^ of);
      C_G:     return !(sf ^ of) && !zf;
      default: return 1'b0;
    endcase
  endfunction

endpackage

>>> src/y86_in_if.sv
// Request channel of the Y86-64 step block: valid/ready plus request fields.
// No dependencies.
interface y86_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [12:0] address;
  logic [7:0] load_data;
  logic [3:0] register_index;

  modport source (output valid, action, address, load_data, register_index, input ready);
  modport sink   (input valid, action, address, load_data, register_index, output ready);
endinterface

>>> src/y86_out_if.sv
// Result channel of the Y86-64 step block: valid/ready plus result fields.
// No dependencies.
interface y86_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] program_counter;
  logic [2:0]  condition_codes;
  logic [63:0] read_value;

  modport source (output valid, status, program_counter, condition_codes, read_value,
                  input ready);
  modport sink   (input valid, status, program_counter, condition_codes, read_value,
                  output ready);
endinterface

>>> src/y86_64_instruction_step.sv
// Y86-64 step block: one request loads a byte, executes one instruction,
// reads a quadword or reads a register. Sequential, one request at a time.
// Memory is read and written one byte at a time. The next request is taken
// once the result register has been loaded. Reset: synchronous; requests
// are refused until the memory sweep has cleared every byte.
module y86_64_instruction_step (
  input logic       clk,
  input logic       rst,
  y86_in_if.sink    item_in,
  y86_out_if.source result_out
);
  import y86_pkg::*;

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LDW   = 5'd1;
  localparam logic [4:0] S_RR1   = 5'd2;
  localparam logic [4:0] S_RR2   = 5'd3;
  localparam logic [4:0] S_EX0   = 5'd4;
  localparam logic [4:0] S_MRD   = 5'd5;
  localparam logic [4:0] S_MCAP  = 5'd6;
  localparam logic [4:0] S_EOP   = 5'd7;
  localparam logic [4:0] S_EB1   = 5'd8;
  localparam logic [4:0] S_EIMS  = 5'd9;
  localparam logic [4:0] S_EIMM  = 5'd10;
  localparam logic [4:0] S_RFA   = 5'd11;
  localparam logic [4:0] S_RFB   = 5'd12;
  localparam logic [4:0] S_RFC   = 5'd13;
  localparam logic [4:0] S_EXEC  = 5'd14;
  localparam logic [4:0] S_MWR   = 5'd15;
  localparam logic [4:0] S_POST  = 5'd16;
  localparam logic [4:0] S_QDONE = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;

  localparam logic [1:0] M_NONE = 2'd0;
  localparam logic [1:0] M_RD   = 2'd1;
  localparam logic [1:0] M_WR   = 2'd2;

  logic [4:0]        state;
  logic [4:0]        ret_state;
  logic [3:0]        cnt;
  logic [MEM_AW-1:0] maddr;
  logic [63:0]       sh;        // byte shift register, little-endian fill

  logic [12:0]       iaddr;
  logic [7:0]        ldata;
  logic [3:0]        ridx;

  logic [63:0]       pc_register;
  logic [2:0]        flag_register;
  logic [63:0]       nxt;
  logic [3:0]        op;
  logic [3:0]        fn;
  logic [3:0]        ra;
  logic [3:0]        rb;
  logic              ok1;
  logic              okc;
  logic [63:0]       imm;
  logic [63:0]       va;
  logic [63:0]       vb;
  logic [1:0]        st;
  logic [63:0]       rv;

  logic              ov;
  logic [1:0]        o_status;
  logic [63:0]       o_pc;
  logic [2:0]        o_cc;
  logic [63:0]       o_rv;

  mem_wr_t           mwr;
  logic [7:0]        mq;
  logic              mbusy;
  rf_wr_t            rwr;
  logic [3:0]        rf_raddr;
  logic [63:0]       rq;

  logic              accept;
  logic [3:0]        opw;
  logic              need_b1;
  logic              imm_field;
  logic [3:0]        src_b;

  // execute-stage decisions
  logic              ex_fault;
  logic [1:0]        ex_st;
  rf_wr_t            ex_wr;
  rf_wr_t            post_wr;
  logic [1:0]        ex_mop;
  logic [63:0]       ex_ea;
  logic [63:0]       ex_wd;
  logic [63:0]       ex_pc;
  logic              ex_fwe;
  logic [2:0]        ex_flg;
  logic [63:0]       sp_dn;
  logic [63:0]       sp_up;
  logic [63:0]       eaddr;

  y86_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .wr    (mwr),
    .raddr (maddr),
    .q     (mq),
    .busy  (mbusy)
  );

  y86_rf u_rf (
    .clk   (clk),
    .rst   (rst),
    .wr    (rwr),
    .raddr (rf_raddr),
    .q     (rq)
  );

  assign item_in.ready = (state == S_IDLE) && !mbusy;
  assign accept        = item_in.valid && item_in.ready;

  assign result_out.valid           = ov;
  assign result_out.status          = o_status;
  assign result_out.program_counter = o_pc;
  assign result_out.condition_codes = o_cc;
  assign result_out.read_value      = o_rv;

  // opcode just fetched sits in the top byte of the shift register
  assign opw       = sh[63:60];
  assign need_b1   = (opw == OP_RRMOV) || (opw == OP_OPQ) || (opw == OP_PUSH) ||
                     (opw == OP_POP) || (opw == OP_IRMOV) || (opw == OP_RMMOV) ||
                     (opw == OP_MRMOV) || (opw == OP_IADD);
  assign imm_field = (op == OP_IRMOV) || (op == OP_RMMOV) || (op == OP_MRMOV) ||
                     (op == OP_JXX) || (op == OP_CALL) || (op == OP_IADD);
  // stack ops take the stack pointer on the B read port
  assign src_b     = ((op == OP_CALL) || (op == OP_RET) || (op == OP_PUSH) ||
                      (op == OP_POP)) ? RSP_ID : rb;

  always_comb begin
    case (state)
      S_RFB:   rf_raddr = src_b;
      S_RR1:   rf_raddr = ridx;
      default: rf_raddr = ra;
    endcase
  end

  always_comb begin
    mwr = '0;
    case (state)
      S_LDW: begin
        mwr.we   = byte_ok(64'(iaddr));
        mwr.addr = MEM_AW'(iaddr);
        mwr.data = ldata;
      end
      S_MWR: begin
        mwr.we   = 1'b1;
        mwr.addr = maddr;
        mwr.data = sh[7:0];
      end
      default: mwr = '0;
    endcase
  end

  assign sp_dn = vb - 64'd8;
  assign sp_up = vb + 64'd8;
  assign eaddr = imm + vb;   // vb reads 0 when rB is absent

  // Instruction semantics; any register update made before a fault stays.
  always_comb begin
    ex_fault = 1'b0;
    ex_st    = ST_AOK;
    ex_wr    = '0;
    ex_mop   = M_NONE;
    ex_ea    = '0;
    ex_wd    = '0;
    ex_pc    = nxt;
    ex_fwe   = 1'b0;
    ex_flg   = flag_register;
    case (op)
      OP_HALT: begin
        ex_fault = 1'b1;
        ex_st    = ST_HLT;
      end
      OP_NOP: ex_fault = 1'b0;
      OP_RRMOV: begin
        if (!ok1) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else if (ra == NO_REG || rb == NO_REG) begin
          ex_fault = 1'b1; ex_st = ST_INS;
        end else if (cond_ok(flag_register, fn)) begin
          ex_wr = '{we: 1'b1, idx: rb, data: va};
        end
      end
      OP_IRMOV: begin
        if (!ok1) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else if (!okc || rb == NO_REG) begin
          ex_fault = 1'b1; ex_st = ST_INS;
        end else begin
          ex_wr = '{we: 1'b1, idx: rb, data: imm};
        end
      end
      OP_RMMOV, OP_MRMOV: begin
        if (!ok1) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else if (!okc || ra == NO_REG) begin
          ex_fault = 1'b1; ex_st = ST_INS;
        end else if (!word_ok(eaddr)) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else begin
          ex_ea  = eaddr;
          ex_wd  = va;
          ex_mop = (op == OP_RMMOV) ? M_WR : M_RD;
        end
      end
      OP_OPQ: begin
        if (!ok1) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else begin
          ex_wr  = '{we: 1'b1, idx: rb, data: alu_res(fn, va, vb)};
          ex_fwe = 1'b1;
          ex_flg = alu_flg(fn, va, vb);
        end
      end
      OP_JXX: begin
        if (!okc) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else if (cond_ok(flag_register, fn)) begin
          ex_pc = imm;
        end
      end
      OP_CALL: begin
        if (!okc) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else begin
          ex_wr = '{we: 1'b1, idx: RSP_ID, data: sp_dn};
          if (!word_ok(sp_dn)) begin
            ex_fault = 1'b1; ex_st = ST_ADR;
          end else begin
            ex_mop = M_WR;
            ex_ea  = sp_dn;
            ex_wd  = nxt;
            ex_pc  = imm;
          end
        end
      end
      OP_RET: begin
        if (!word_ok(vb)) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else begin
          ex_mop = M_RD;
          ex_ea  = vb;
        end
      end
      OP_PUSH: begin
        if (!ok1) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else if (ra == NO_REG) begin
          ex_fault = 1'b1; ex_st = ST_INS;
        end else begin
          ex_wr = '{we: 1'b1, idx: RSP_ID, data: sp_dn};
          if (!word_ok(sp_dn)) begin
            ex_fault = 1'b1; ex_st = ST_ADR;
          end else begin
            ex_mop = M_WR;
            ex_ea  = sp_dn;
            ex_wd  = va;
          end
        end
      end
      OP_POP: begin
        if (!ok1) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else if (ra == NO_REG) begin
          ex_fault = 1'b1; ex_st = ST_INS;
        end else begin
          ex_wr = '{we: 1'b1, idx: RSP_ID, data: sp_up};
          if (!word_ok(vb)) begin
            ex_fault = 1'b1; ex_st = ST_ADR;
          end else begin
            ex_mop = M_RD;
            ex_ea  = vb;
          end
        end
      end
      OP_IADD: begin
        if (!ok1) begin
          ex_fault = 1'b1; ex_st = ST_ADR;
        end else if (!okc || rb == NO_REG) begin
          ex_fault = 1'b1; ex_st = ST_INS;
        end else begin
          ex_wr  = '{we: 1'b1, idx: rb, data: vb + imm};
          ex_fwe = 1'b1;
          ex_flg = alu_flg(ALU_ADD, imm, vb);
        end
      end
      default: begin
        ex_fault = 1'b1;
        ex_st    = ST_INS;
      end
    endcase
  end

  // second write after the data load: ret bumps the stack, mrmovq/popq load rA
  always_comb begin
    if (op == OP_RET) begin
      post_wr = '{we: 1'b1, idx: RSP_ID, data: sp_up};
    end else begin
      post_wr = '{we: 1'b1, idx: ra, data: sh};
    end
  end

  always_comb begin
    case (state)
      S_EXEC:  rwr = ex_wr;
      S_POST:  rwr = post_wr;
      default: rwr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pc_register   <= '0;
      flag_register <= FLAGS_RESET;
      ov            <= 1'b0;
    end else begin
      if (state == S_FIN && (!ov || result_out.ready)) begin
        ov <= 1'b1;
      end else if (result_out.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            iaddr <= item_in.address;
            ldata <= item_in.load_data;
            ridx  <= item_in.register_index;
            st    <= ST_AOK;
            rv    <= '0;
            case (item_in.action)
              ACT_LOAD: state <= S_LDW;
              ACT_EXEC: state <= S_EX0;
              ACT_RDQ: begin
                if (word_ok(64'(item_in.address))) begin
                  maddr     <= MEM_AW'(item_in.address);
                  cnt       <= 4'd8;
                  ret_state <= S_QDONE;
                  state     <= S_MRD;
                end else begin
                  state <= S_FIN;
                end
              end
              default: state <= S_RR1;
            endcase
          end
        end
        S_LDW: state <= S_FIN;
        S_RR1: state <= S_RR2;
        S_RR2: begin
          rv    <= rq;
          state <= S_FIN;
        end
        S_EX0: begin
          ok1 <= 1'b1;
          okc <= 1'b1;
          ra  <= '0;
          rb  <= '0;
          imm <= '0;
          if (!byte_ok(pc_register)) begin
            st    <= ST_ADR;
            state <= S_FIN;
          end else begin
            maddr     <= MEM_AW'(pc_register);
            cnt       <= 4'd1;
            ret_state <= S_EOP;
            nxt       <= pc_register + 64'd1;
            state     <= S_MRD;
          end
        end
        S_MRD: state <= S_MCAP;
        S_MCAP: begin
          sh    <= {mq, sh[63:8]};
          maddr <= maddr + 1'b1;
          cnt   <= cnt - 4'd1;
          state <= (cnt == 4'd1) ? ret_state : S_MRD;
        end
        S_EOP: begin
          op <= sh[63:60];
          fn <= sh[59:56];
          if (need_b1) begin
            if (byte_ok(nxt)) begin
              maddr     <= MEM_AW'(nxt);
              cnt       <= 4'd1;
              ret_state <= S_EB1;
              state     <= S_MRD;
            end else begin
              ok1   <= 1'b0;
              nxt   <= nxt + 64'd1;
              state <= S_EIMS;
            end
          end else begin
            state <= S_EIMS;
          end
        end
        S_EB1: begin
          ra    <= sh[63:60];
          rb    <= sh[59:56];
          nxt   <= nxt + 64'd1;
          state <= S_EIMS;
        end
        S_EIMS: begin
          if (imm_field) begin
            if (word_ok(nxt)) begin
              maddr     <= MEM_AW'(nxt);
              cnt       <= 4'd8;
              ret_state <= S_EIMM;
              state     <= S_MRD;
            end else begin
              okc   <= 1'b0;
              nxt   <= nxt + 64'd8;
              state <= S_RFA;
            end
          end else begin
            state <= S_RFA;
          end
        end
        S_EIMM: begin
          imm   <= sh;
          nxt   <= nxt + 64'd8;
          state <= S_RFA;
        end
        S_RFA: state <= S_RFB;
        S_RFB: begin
          va    <= rq;
          state <= S_RFC;
        end
        S_RFC: begin
          vb    <= rq;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (ex_fault) begin
            st    <= ex_st;
            state <= S_FIN;
          end else begin
            if (ex_fwe) begin
              flag_register <= ex_flg;
            end
            if (op != OP_RET) begin
              pc_register <= ex_pc;
            end
            case (ex_mop)
              M_WR: begin
                sh    <= ex_wd;
                maddr <= MEM_AW'(ex_ea);
                cnt   <= 4'd8;
                state <= S_MWR;
              end
              M_RD: begin
                maddr     <= MEM_AW'(ex_ea);
                cnt       <= 4'd8;
                ret_state <= S_POST;
                state     <= S_MRD;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_MWR: begin
          sh    <= {8'h00, sh[63:8]};
          maddr <= maddr + 1'b1;
          cnt   <= cnt - 4'd1;
          if (cnt == 4'd1) begin
            state <= S_FIN;
          end
        end
        S_POST: begin
          if (op == OP_RET) begin
            pc_register <= sh;
          end
          state <= S_FIN;
        end
        S_QDONE: begin
          rv    <= sh;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!ov || result_out.ready) begin
            o_status <= st;
            o_pc     <= pc_register;
            o_cc     <= flag_register;
            o_rv     <= rv;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // memory is never written by the datapath outside the load and store states
  a_mem_wr_state: assert property (@(posedge clk) disable iff (rst)
    mwr.we |-> (state == S_LDW || state == S_MWR))
    else $error("memory write outside store states");

  // no request is taken while the reset sweep runs
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    mbusy |-> !item_in.ready)
    else $error("request accepted during memory clear");

  // the PC only moves in the execute or post-load step
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC && state != S_POST) |=> $stable(pc_register))
    else $error("pc changed outside execute");

  // register file writes only come from execute or post-load
  a_rf_wr_state: assert property (@(posedge clk) disable iff (rst)
    rwr.we |-> (state == S_EXEC || state == S_POST))
    else $error("register write outside execute");

endmodule

>>> src/y86_mem.sv
// Byte-wide main memory, one write and one registered read per cycle.
// Sweeps itself to zero after reset, ignoring writes meanwhile. Depends on y86_pkg.
module y86_mem (
  input  logic                     clk,
  input  logic                     rst,
  input  y86_pkg::mem_wr_t         wr,
  input  logic [y86_pkg::MEM_AW-1:0] raddr,
  output logic [7:0]               q,
  output logic                     busy
);
  import y86_pkg::*;

  logic [7:0]        mem [MEM_BYTES];
  logic [MEM_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == MEM_AW'(MEM_BYTES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 8'h00;
    end else if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    q <= mem[raddr];
  end
endmodule

>>> src/y86_rf.sv
// Program register file, 15 x 64, registered read; id 15 reads 0, writes dropped.
// Valid bits stand in for the reset clear. Depends on y86_pkg.
module y86_rf (
  input  logic             clk,
  input  logic             rst,
  input  y86_pkg::rf_wr_t  wr,
  input  logic [3:0]       raddr,
  output logic [63:0]      q
);
  import y86_pkg::*;

  logic [63:0]         regs [NUM_REGS];
  logic [NUM_REGS-1:0] valid;
  logic [63:0]         rdata;
  logic                rok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.we && (wr.idx < 4'(NUM_REGS))) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && (wr.idx < 4'(NUM_REGS))) begin
      regs[wr.idx] <= wr.data;
    end
    rdata <= regs[raddr];
    rok   <= (raddr < 4'(NUM_REGS)) && valid[raddr];
  end

  assign q = rok ? rdata : '0;
endmodule

>>> test/y86_step_checker.sv
// Checker for the Y86-64 step block: watches both channels, keeps its own
// machine state and compares every result. Depends on y86_pkg and the channel interfaces.
`timescale 1ns / 1ps
module y86_step_checker (
  input  logic        clk,
  input  logic        rst,
  y86_in_if           req,
  y86_out_if          res,
  output int          fails,
  output int          pending,
  output logic [63:0] last_pc,
  output logic [63:0] last_rv,
  output int          n_exec,
  output int          n_fault
);
  import y86_pkg::*;

  typedef struct packed {
    logic [1:0]  st;
    logic [63:0] pc;
    logic [2:0]  cc;
    logic [63:0] rv;
  } step_result_t;

  step_result_t want_q[$];

  logic [7:0]  mem_m  [MEM_BYTES];
  logic [63:0] regs_m [NUM_REGS];
  logic [63:0] pc_m;
  logic [2:0]  cc_m;

  initial begin
    fails   = 0;
    n_exec  = 0;
    n_fault = 0;
    pending = 0;
    last_pc = '0;
    last_rv = '0;
  end

  task automatic clear_model();
    for (int i = 0; i < MEM_BYTES; i++) mem_m[i] = 8'h00;
    for (int i = 0; i < NUM_REGS; i++) regs_m[i] = '0;
    pc_m = '0;
    cc_m = FLAGS_RESET;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    fails++;
  endtask

  function automatic logic in_mem(logic [63:0] a);
    return a < 64'(MEM_BYTES);
  endfunction

  function automatic logic word_fits(logic [63:0] a);
    return a <= 64'(MEM_BYTES - 8);
  endfunction

  function automatic logic [63:0] get_q(logic [63:0] a);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = mem_m[a + i];
    return v;
  endfunction

  function automatic void put_q(logic [63:0] a, logic [63:0] v);
    for (int i = 0; i < 8; i++) mem_m[a + i] = v[8*i +: 8];
  endfunction

  function automatic logic [63:0] reg_get(logic [3:0] id);
    return (id < NUM_REGS) ? regs_m[id] : '0;
  endfunction

  function automatic void reg_put(logic [3:0] id, logic [63:0] v);
    if (id < NUM_REGS) regs_m[id] = v;
  endfunction

  function automatic logic [63:0] calc(logic [3:0] fn, logic [63:0] a, logic [63:0] b);
    case (fn)
      ALU_ADD: return a + b;
      ALU_SUB: return b - a;
      ALU_AND: return a & b;
      ALU_XOR: return a ^ b;
      default: return '0;
    endcase
  endfunction

  // sub overflow keeps the "a strictly positive" test
  function automatic logic [2:0] calc_cc(logic [3:0] fn, logic [63:0] a, logic [63:0] b);
    logic [63:0] v;
    logic        ov;
    logic        a_pos;
    v     = calc(fn, a, b);
    a_pos = (a != 0) && !a[63];
    ov    = 1'b0;
    if (fn == ALU_ADD) ov = (a[63] == b[63]) && (v[63] != a[63]);
    else if (fn == ALU_SUB) ov = (a_pos == b[63]) && (v[63] != b[63]);
    return {v == 0, v[63], ov};
  endfunction

  function automatic logic taken(logic [2:0] cc, logic [3:0] c);
    logic lt;
    lt = cc[1] ^ cc[0];
    case (c)
      C_ALW:   return 1'b1;
      C_LE:    return lt | cc[2];
      C_L:     return lt;
      C_E:     return cc[2];
      C_NE:    return !cc[2];
      C_GE:    return !lt;
      C_G:     return !lt && !cc[2];
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [1:0] run_instr();
    logic [63:0] nx, imm, va, vb;
    logic [7:0]  b0, b1;
    logic [3:0]  op, fn, ra, rb;
    logic        ok1, okc;
    nx  = pc_m;
    imm = '0;
    ra  = '0;
    rb  = '0;
    ok1 = 1'b1;
    okc = 1'b1;
    if (!in_mem(nx)) return ST_ADR;
    b0 = mem_m[nx];
    nx = nx + 1;
    op = b0[7:4];
    fn = b0[3:0];
    case (op)
      OP_RRMOV, OP_OPQ, OP_PUSH, OP_POP, OP_IRMOV, OP_RMMOV, OP_MRMOV, OP_IADD: begin
        b1  = 8'h00;
        ok1 = in_mem(nx);
        if (ok1) b1 = mem_m[nx];
        nx = nx + 1;
        ra = b1[7:4];
        rb = b1[3:0];
      end
      default: ;
    endcase
    case (op)
      OP_IRMOV, OP_RMMOV, OP_MRMOV, OP_JXX, OP_CALL, OP_IADD: begin
        okc = word_fits(nx);
        if (okc) imm = get_q(nx);
        nx = nx + 8;
      end
      default: ;
    endcase
    case (op)
      OP_HALT: return ST_HLT;
      OP_NOP: ;
      OP_RRMOV: begin
        if (!ok1) return ST_ADR;
        if (ra == NO_REG || rb == NO_REG) return ST_INS;
        if (taken(cc_m, fn)) reg_put(rb, reg_get(ra));
      end
      OP_IRMOV: begin
        if (!ok1) return ST_ADR;
        if (!okc || rb == NO_REG) return ST_INS;
        reg_put(rb, imm);
      end
      OP_RMMOV, OP_MRMOV: begin
        if (!ok1) return ST_ADR;
        if (!okc || ra == NO_REG) return ST_INS;
        imm = imm + reg_get(rb);
        if (!word_fits(imm)) return ST_ADR;
        if (op == OP_RMMOV) put_q(imm, reg_get(ra));
        else reg_put(ra, get_q(imm));
      end
      OP_OPQ: begin
        if (!ok1) return ST_ADR;
        va = reg_get(ra);
        vb = reg_get(rb);
        reg_put(rb, calc(fn, va, vb));
        cc_m = calc_cc(fn, va, vb);
      end
      OP_JXX: begin
        if (!okc) return ST_ADR;
        if (taken(cc_m, fn)) nx = imm;
      end
      OP_CALL: begin
        if (!okc) return ST_ADR;
        va = reg_get(RSP_ID) - 8;
        reg_put(RSP_ID, va);
        if (!word_fits(va)) return ST_ADR;
        put_q(va, nx);
        nx = imm;
      end
      OP_RET: begin
        vb = reg_get(RSP_ID);
        if (!word_fits(vb)) return ST_ADR;
        va = get_q(vb);
        reg_put(RSP_ID, vb + 8);
        nx = va;
      end
      OP_PUSH: begin
        if (!ok1) return ST_ADR;
        if (ra == NO_REG) return ST_INS;
        va = reg_get(ra);
        vb = reg_get(RSP_ID) - 8;
        reg_put(RSP_ID, vb);
        if (!word_fits(vb)) return ST_ADR;
        put_q(vb, va);
      end
      OP_POP: begin
        if (!ok1) return ST_ADR;
        if (ra == NO_REG) return ST_INS;
        vb = reg_get(RSP_ID);
        reg_put(RSP_ID, vb + 8);
        if (!word_fits(vb)) return ST_ADR;
        reg_put(ra, get_q(vb));
      end
      OP_IADD: begin
        if (!ok1) return ST_ADR;
        if (!okc || rb == NO_REG) return ST_INS;
        vb = reg_get(rb);
        reg_put(rb, vb + imm);
        cc_m = calc_cc(ALU_ADD, imm, vb);
      end
      default: return ST_INS;
    endcase
    pc_m = nx;
    return ST_AOK;
  endfunction

  function automatic step_result_t predict(logic [1:0] act, logic [12:0] addr,
                                           logic [7:0] data, logic [3:0] idx);
    step_result_t r;
    r.st = ST_AOK;
    r.rv = '0;
    case (act)
      ACT_LOAD:  if (in_mem(64'(addr))) mem_m[addr] = data;
      ACT_EXEC: begin
        r.st = run_instr();
        n_exec++;
        if (r.st != ST_AOK) n_fault++;
      end
      ACT_RDQ:   if (word_fits(64'(addr))) r.rv = get_q(64'(addr));
      default:   r.rv = reg_get(idx);
    endcase
    r.pc = pc_m;
    r.cc = cc_m;
    return r;
  endfunction

  initial clear_model();

  always @(posedge clk) begin
    step_result_t e;
    if (rst) begin
      clear_model();
      want_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        e = predict(req.action, req.address, req.load_data, req.register_index);
        want_q.push_back(e);
      end
      if (res.valid && res.ready) begin
        if (want_q.size() == 0) begin
          report("result with nothing pending", res.program_counter, 0);
        end else begin
          e = want_q.pop_front();
          if (res.status !== e.st) report("status", res.status, e.st);
          if (res.program_counter !== e.pc) report("pc", res.program_counter, e.pc);
          if (res.condition_codes !== e.cc) report("flags", res.condition_codes, e.cc);
          if (res.read_value !== e.rv) report("read value", res.read_value, e.rv);
          last_pc <= e.pc;
          last_rv <= e.rv;
        end
      end
    end
    pending <= want_q.size();
  end

endmodule

>>> test/y86_64_instruction_step_test.sv
// Testbench top for the Y86-64 step block: builds programs one instruction at a
// time, drives requests and gives the verdict. Depends on y86_pkg, the interfaces, the checker.
`timescale 1ns / 1ps
module y86_64_instruction_step_test;
  import y86_pkg::*;

  localparam int LIMIT     = 800000;  // cycles
  localparam int N_ITEMS   = 1200;
  localparam logic [63:0] FAR_PC = 64'd8100;  // past this, redirect back low

  logic clk;
  logic rst;
  int   cycles;
  int   n_items;
  int   idle_pct;   // sender gap odds, percent per cycle
  int   stall_pct;  // receiver stall odds

  int          fails, pending, n_exec, n_fault;
  logic [63:0] last_pc, last_rv;

  y86_in_if  req ();
  y86_out_if res ();

  y86_64_instruction_step DUT (
    .clk        (clk),
    .rst        (rst),
    .item_in    (req),
    .result_out (res)
  );

  y86_step_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res     (res),
    .fails   (fails),
    .pending (pending),
    .last_pc (last_pc),
    .last_rv (last_rv),
    .n_exec  (n_exec),
    .n_fault (n_fault)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure per phase.
  initial res.ready = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Phase follows progress: clean, sender gaps, receiver stalls, both.
  task automatic set_phase();
    int ph;
    ph = n_items * 4 / N_ITEMS;
    case (ph)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 63; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 63; end
      default: begin idle_pct = 32; stall_pct = 32; end
    endcase
  endtask

  // One request; valid stays high across back-to-back requests.
  task automatic send(input logic [1:0] act, input logic [12:0] addr,
                      input logic [7:0] dat, input logic [3:0] idx);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.action         <= act;
    req.address        <= addr;
    req.load_data      <= dat;
    req.register_index <= idx;
    req.valid          <= 1'b1;
    do @(posedge clk); while (!req.ready);
    n_items++;
  endtask

  // Drop valid and wait until every result is back, so last_pc/last_rv hold.
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic put_byte(input logic [63:0] a, input logic [7:0] v);
    send(ACT_LOAD, a[12:0], v, 4'd0);
  endtask

  task automatic put_quad(input logic [63:0] a, input logic [63:0] v);
    for (int i = 0; i < 8; i++) put_byte(a + i, v[8*i +: 8]);
  endtask

  task automatic step();
    send(ACT_EXEC, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
         4'($urandom_range(0, 15)));
  endtask

  function automatic logic [3:0] pick_reg();
    return ($urandom_range(99) < 8) ? NO_REG : 4'($urandom_range(0, 14));
  endfunction

  // Operand values: small addresses, random words, zero, plus sign and carry extremes.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 6))
      0, 1:    return 64'($urandom_range(0, 8191));
      2:       return {$urandom, $urandom};
      3:       return 64'h8000_0000_0000_0000;
      4:       return 64'h7FFF_FFFF_FFFF_FFFF;
      5:       return '1;
      default: return '0;
    endcase
  endfunction

  // Noise between instructions: reads anywhere, stray byte loads.
  task automatic noise();
    case ($urandom_range(0, 2))
      0:       send(ACT_RDQ, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)), 4'd0);
      1:       send(ACT_RDREG, 13'($urandom_range(0, 8191)), 8'h00,
                    4'($urandom_range(0, 15)));
      default: send(ACT_LOAD, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
                    4'($urandom_range(0, 15)));
    endcase
  endtask

  // Write one instruction at the current PC and execute it.
  task automatic one_instr();
    logic [63:0] p, imm, sp;
    logic [3:0]  op, fn, ra, rb;
    logic        has_regs, has_imm;
    int          r;
    settle();
    p  = last_pc;
    r  = $urandom_range(99);
    ra = pick_reg();
    rb = pick_reg();
    if (r < 4) op = 4'($urandom_range(13, 15));      // undefined opcodes
    else if (r < 14) op = OP_IRMOV;                  // keep registers stirred
    else op = 4'($urandom_range(0, 12));
    if (op == OP_OPQ) fn = ($urandom_range(99) < 92) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    else fn = ($urandom_range(99) < 90) ? 4'($urandom_range(0, 6)) : 4'($urandom);
    case (op)
      OP_JXX, OP_CALL: imm = 64'($urandom_range(0, 7800));
      OP_RMMOV, OP_MRMOV: begin
        imm = ($urandom_range(99) < 80) ? 64'($urandom_range(0, 8191)) : pick_value();
        if ($urandom_range(1)) rb = NO_REG;
      end
      default: imm = pick_value();
    endcase
    // a valid stack pointer now and then, so call/ret/push/pop get through
    if (op == OP_IRMOV && $urandom_range(99) < 25) begin
      rb  = RSP_ID;
      imm = 64'($urandom_range(16, 8184));
    end
    if (p > FAR_PC) begin
      op  = OP_JXX;
      fn  = C_ALW;
      imm = 64'($urandom_range(0, 7800));
    end
    if (op == OP_RET) begin
      // plant a return address in range so the PC stays in memory
      send(ACT_RDREG, 13'd0, 8'h00, RSP_ID);
      settle();
      sp = last_rv;
      if (sp <= 64'(MEM_BYTES - 8)) put_quad(sp, 64'($urandom_range(0, 7800)));
    end
    has_regs = (op == OP_RRMOV || op == OP_IRMOV || op == OP_RMMOV || op == OP_MRMOV ||
                op == OP_OPQ || op == OP_PUSH || op == OP_POP || op == OP_IADD);
    has_imm  = (op == OP_IRMOV || op == OP_RMMOV || op == OP_MRMOV || op == OP_JXX ||
                op == OP_CALL || op == OP_IADD);
    put_byte(p, {op, fn});
    if (has_regs) put_byte(p + 1, {ra, rb});
    if (has_imm) put_quad(has_regs ? p + 2 : p + 1, imm);
    step();
  endtask

  initial begin
    logic [63:0] p;
    cycles    = 0;
    n_items   = 0;
    idle_pct  = 0;
    stall_pct = 0;
    req.valid          <= 1'b0;
    req.action         <= ACT_LOAD;
    req.address        <= '0;
    req.load_data      <= '0;
    req.register_index <= '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: cleared memory executes halt, reads at the edges, reg 15.
    step();
    send(ACT_RDREG, 13'd0, 8'h00, NO_REG);
    send(ACT_RDREG, 13'd0, 8'h00, 4'd14);
    send(ACT_RDQ, 13'd8184, 8'h00, 4'd0);
    send(ACT_RDQ, 13'd8185, 8'h00, 4'd0);
    put_byte(64'd8191, 8'hFF);
    send(ACT_RDQ, 13'd8184, 8'h00, 4'd0);
    send(ACT_RDQ, 13'h1FFF, 8'h00, 4'd0);
    // OPq ignores a missing register field
    put_byte(64'd0, {OP_OPQ, ALU_SUB});
    put_byte(64'd1, {NO_REG, RSP_ID});
    step();
    send(ACT_RDREG, 13'd0, 8'h00, RSP_ID);

    // Random: one instruction at a time, with some noise around it.
    while (n_items < N_ITEMS) begin
      set_phase();
      if ($urandom_range(99) < 30) noise();
      one_instr();
    end

    // Tail: fetch running off the end of memory.
    settle();
    p = last_pc;
    put_byte(p, {OP_JXX, C_ALW});
    put_quad(p + 1, 64'(MEM_BYTES - 7));
    step();
    put_byte(64'(MEM_BYTES - 7), {OP_IRMOV, 4'h0});
    put_byte(64'(MEM_BYTES - 6), {NO_REG, 4'd0});
    step();                                            // immediate unreadable
    put_byte(64'(MEM_BYTES - 7), {OP_JXX, C_ALW});
    step();                                            // jump target unreadable
    for (int i = 7; i > 1; i--) put_byte(64'(MEM_BYTES - i), {OP_NOP, 4'h0});
    put_byte(64'(MEM_BYTES - 1), {OP_RRMOV, C_ALW});
    repeat (7) step();                                 // last one: register byte gone
    put_byte(64'(MEM_BYTES - 1), {OP_NOP, 4'h0});
    repeat (2) step();                                 // PC past memory
    send(ACT_RDREG, 13'd0, 8'h00, RSP_ID);

    settle();
    repeat (60) @(posedge clk);
    $display("%0d requests sent, %0d instructions executed, %0d ended in a fault or halt",
             n_items, n_exec, n_fault);
    $display("idle phases: none, sender gaps, receiver stalls, both");
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
